FILE: hdl/sbc_pkg.sv
package sbc_pkg;

  localparam int NUM_PE = 64;

  localparam int CNT_W  = 7;
  localparam int SEQ_W  = 32;
  localparam int CFGI_W = 3;

  typedef enum logic [1:0] {
    CMD_READY   = 2'd0,
    CMD_DONE    = 2'd1,
    CMD_START   = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_READY        = 4'd0,
    ST_DONE         = 4'd1,
    ST_STARTED      = 4'd2,
    ST_MAX          = 4'd3,
    ST_IGNORED      = 4'd4,
    ST_EARLY_DONE   = 4'd5,
    ST_SEQ_MISMATCH = 4'd6,
    ST_STRAY_START  = 4'd7,
    ST_FATAL        = 4'd8,
    ST_HALTED       = 4'd9
  } status_t;

  typedef enum logic [CFGI_W-1:0] {
    REG_PE_COUNT  = 3'd0,
    REG_START_SEQ = 3'd1,
    REG_MAX_STEPS = 3'd2,
    REG_REQ_ALL   = 3'd3,
    REG_STRICT    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] elem_cnt;
    logic [SEQ_W-1:0] base_seq;
    logic [SEQ_W-1:0] step_limit;
    logic             all_ready_req;
    logic             strict_check;
  } cfg_t;

  typedef struct packed {
    logic [3:0]       status;
    logic [SEQ_W-1:0] current_step;
    logic [SEQ_W-1:0] completed_steps;
    logic [SEQ_W-1:0] warnings;
  } res_t;

endpackage

FILE: hdl/sbc_cfg.sv
module sbc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sbc_pkg::CFGI_W-1:0] cfg_index,
  input  logic [sbc_pkg::SEQ_W-1:0]  cfg_data,
  output sbc_pkg::cfg_t              cfg
);

  sbc_pkg::cfg_t cfg_r;
  sbc_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        sbc_pkg::REG_PE_COUNT:  cfg_nxt.elem_cnt   = cfg_data[sbc_pkg::CNT_W-1:0];
        sbc_pkg::REG_START_SEQ: cfg_nxt.base_seq   = cfg_data;
        sbc_pkg::REG_MAX_STEPS: cfg_nxt.step_limit = cfg_data;
        sbc_pkg::REG_REQ_ALL:   cfg_nxt.all_ready_req = cfg_data[0];
        sbc_pkg::REG_STRICT:    cfg_nxt.strict_check = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.elem_cnt      <= sbc_pkg::CNT_W'(sbc_pkg::NUM_PE);
      cfg_r.base_seq      <= sbc_pkg::SEQ_W'(1);
      cfg_r.step_limit    <= '0;
      cfg_r.all_ready_req <= 1'b1;
      cfg_r.strict_check  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hdl/sbc_core.sv
module sbc_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sbc_pkg::cfg_t             cfg,
  input  logic                      apply,
  input  logic [1:0]                cmd,
  input  logic [sbc_pkg::CNT_W-1:0] elem_id,
  input  logic [sbc_pkg::SEQ_W-1:0] step_number,
  output sbc_pkg::res_t             res
);

  localparam logic [sbc_pkg::SEQ_W-1:0] SEQ_ONE = sbc_pkg::SEQ_W'(1);
  localparam logic [sbc_pkg::SEQ_W-1:0] SEQ_MAX = '1;

  logic [sbc_pkg::NUM_PE-1:0] ready_r, ready_nxt;
  logic [sbc_pkg::NUM_PE-1:0] done_r, done_nxt;
  logic                       running_r, running_nxt;
  logic                       halted_r, halted_nxt;
  logic [sbc_pkg::SEQ_W-1:0]  seq_r, seq_nxt;
  logic [sbc_pkg::SEQ_W-1:0]  total_r, total_nxt;
  logic [sbc_pkg::SEQ_W-1:0]  warn_r, warn_nxt;

  logic [sbc_pkg::CNT_W-1:0]  act_n;
  logic [sbc_pkg::NUM_PE-1:0] mask;
  logic [sbc_pkg::NUM_PE-1:0] sel;
  logic [sbc_pkg::NUM_PE-1:0] ready_set;
  logic [sbc_pkg::NUM_PE-1:0] done_set;
  logic [sbc_pkg::SEQ_W-1:0]  total_inc;
  logic [3:0]                 status;
  logic                       viol;
  logic [3:0]                 viol_st;

  always_comb begin
    if (cfg.elem_cnt == '0) begin
      act_n = sbc_pkg::CNT_W'(1);
    end else if (cfg.elem_cnt > sbc_pkg::CNT_W'(sbc_pkg::NUM_PE)) begin
      act_n = sbc_pkg::CNT_W'(sbc_pkg::NUM_PE);
    end else begin
      act_n = cfg.elem_cnt;
    end
    for (int i = 0; i < sbc_pkg::NUM_PE; i++) begin
      mask[i] = sbc_pkg::CNT_W'(i) < act_n;
      sel[i]  = elem_id == sbc_pkg::CNT_W'(i);
    end
  end

  assign ready_set = ready_r | sel;
  assign done_set  = done_r | sel;
  assign total_inc = total_r + SEQ_ONE;

  always_comb begin
    ready_nxt   = ready_r;
    done_nxt    = done_r;
    running_nxt = running_r;
    halted_nxt  = halted_r;
    seq_nxt     = seq_r;
    total_nxt   = total_r;
    warn_nxt    = warn_r;
    viol        = 1'b0;
    viol_st     = sbc_pkg::ST_IGNORED;
    status      = sbc_pkg::ST_IGNORED;

    if (halted_r) begin
      status = sbc_pkg::ST_HALTED;
    end else if (elem_id >= act_n || cmd == sbc_pkg::CMD_UNKNOWN) begin
      status = sbc_pkg::ST_IGNORED;
    end else begin
      case (cmd)
        sbc_pkg::CMD_READY: begin
          ready_nxt = ready_set;
          status    = sbc_pkg::ST_READY;
          if (!running_r && (!cfg.all_ready_req || (ready_set & mask) == mask)) begin
            running_nxt = 1'b1;
            seq_nxt     = (cfg.base_seq == '0) ? SEQ_ONE : cfg.base_seq;
            done_nxt    = '0;
            status      = sbc_pkg::ST_STARTED;
          end
        end
        sbc_pkg::CMD_DONE: begin
          if (!running_r) begin
            viol    = 1'b1;
            viol_st = sbc_pkg::ST_EARLY_DONE;
          end else if (step_number != seq_r) begin
            viol    = 1'b1;
            viol_st = sbc_pkg::ST_SEQ_MISMATCH;
          end else begin
            done_nxt = done_set;
            status   = sbc_pkg::ST_DONE;
            if ((done_set & mask) == mask) begin
              total_nxt = total_inc;
              if (cfg.step_limit != '0 && total_inc >= cfg.step_limit) begin
                status = sbc_pkg::ST_MAX;
              end else begin
                seq_nxt  = seq_r + SEQ_ONE;
                done_nxt = '0;
                status   = sbc_pkg::ST_STARTED;
              end
            end
          end
        end
        default: begin
          viol    = 1'b1;
          viol_st = sbc_pkg::ST_STRAY_START;
        end
      endcase
      if (viol) begin
        if (cfg.strict_check) begin
          halted_nxt = 1'b1;
          status     = sbc_pkg::ST_FATAL;
        end else begin
          if (warn_r != SEQ_MAX) begin
            warn_nxt = warn_r + SEQ_ONE;
          end
          status = viol_st;
        end
      end
    end

    res.status          = status;
    res.current_step    = seq_nxt;
    res.completed_steps = total_nxt;
    res.warnings        = warn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r   <= '0;
      done_r    <= '0;
      running_r <= 1'b0;
      halted_r  <= 1'b0;
      seq_r     <= '0;
      total_r   <= '0;
      warn_r    <= '0;
    end else if (apply) begin
      ready_r   <= ready_nxt;
      done_r    <= done_nxt;
      running_r <= running_nxt;
      halted_r  <= halted_nxt;
      seq_r     <= seq_nxt;
      total_r   <= total_nxt;
      warn_r    <= warn_nxt;
    end
  end

endmodule

FILE: hdl/step_barrier_controller.sv
// Path: input register, then barrier update into the result register;
//   out_valid rises when the result register loads.
// Throughput: one item per cycle while the output is not stalled; state is
//   updated in the same cycle the result register loads, so back-to-back
//   items see each other's effects.
// Reset (rst_n low, synchronous): barrier state, counters and valid flags
//   clear; configuration returns to its defaults.
module step_barrier_controller (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_cmd,
  input  logic [sbc_pkg::CNT_W-1:0]  in_elem_id,
  input  logic [sbc_pkg::SEQ_W-1:0]  in_step_number,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [3:0]                 out_status,
  output logic [sbc_pkg::SEQ_W-1:0]  out_current_step,
  output logic [sbc_pkg::SEQ_W-1:0]  out_completed_steps,
  output logic [sbc_pkg::SEQ_W-1:0]  out_warnings,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sbc_pkg::CFGI_W-1:0] cfg_index,
  input  logic [sbc_pkg::SEQ_W-1:0]  cfg_data
);

  sbc_pkg::cfg_t cfg;
  sbc_pkg::res_t res;
  sbc_pkg::res_t res_r;

  logic                      vld_r;
  logic [1:0]                cmd_r;
  logic [sbc_pkg::CNT_W-1:0] idx_r;
  logic [sbc_pkg::SEQ_W-1:0] seq_r;
  logic                      out_vld_r;
  logic                      out_free;
  logic                      adv;

  assign out_free = !out_vld_r || !out_stall;
  assign adv      = vld_r && out_free;
  assign in_stall = vld_r && !out_free;

  sbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sbc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .apply       (adv),
    .cmd         (cmd_r),
    .elem_id     (idx_r),
    .step_number (seq_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        vld_r <= in_valid;
      end
      if (out_free) begin
        out_vld_r <= vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r <= in_cmd;
      idx_r <= in_elem_id;
      seq_r <= in_step_number;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_status          = res_r.status;
  assign out_current_step    = res_r.current_step;
  assign out_completed_steps = res_r.completed_steps;
  assign out_warnings        = res_r.warnings;

endmodule

FILE: hdl/sbc_checker.sv
module sbc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [3:0]                 out_status,
  input logic [sbc_pkg::SEQ_W-1:0]  out_current_step,
  input logic [sbc_pkg::SEQ_W-1:0]  out_completed_steps,
  input logic [sbc_pkg::SEQ_W-1:0]  out_warnings
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_current_step) && $stable(out_completed_steps) && $stable(out_warnings))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("valid after reset");

  a_fatal_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_status == sbc_pkg::ST_FATAL |=>
      !out_valid || out_status == sbc_pkg::ST_HALTED)
    else $error("item after fatal not halted");

endmodule

bind step_barrier_controller sbc_checker u_sbc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_status          (out_status),
  .out_current_step    (out_current_step),
  .out_completed_steps (out_completed_steps),
  .out_warnings        (out_warnings)
);

FILE: test/step_barrier_controller_tb.sv
`timescale 1ns / 100ps

module step_barrier_controller_tb;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    sbc_pkg::cmd_t             cmd;
    logic [sbc_pkg::CNT_W-1:0] pe;
    logic [sbc_pkg::SEQ_W-1:0] seq;
  } pe_report_t;

  typedef struct {
    sbc_pkg::status_t          status;
    logic [sbc_pkg::SEQ_W-1:0] step;
    logic [sbc_pkg::SEQ_W-1:0] total;
    logic [sbc_pkg::SEQ_W-1:0] warns;
  } barrier_result_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_cmd = 2'd0;
  logic [sbc_pkg::CNT_W-1:0]  in_elem_id = '0;
  logic [sbc_pkg::SEQ_W-1:0]  in_step_number = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [3:0]                 out_status;
  logic [sbc_pkg::SEQ_W-1:0]  out_current_step;
  logic [sbc_pkg::SEQ_W-1:0]  out_completed_steps;
  logic [sbc_pkg::SEQ_W-1:0]  out_warnings;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [sbc_pkg::CFGI_W-1:0] cfg_index = '0;
  logic [sbc_pkg::SEQ_W-1:0]  cfg_data = '0;

  step_barrier_controller dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_elem_id          (in_elem_id),
    .in_step_number      (in_step_number),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_current_step    (out_current_step),
    .out_completed_steps (out_completed_steps),
    .out_warnings        (out_warnings),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // barrier shadow: configuration and state
  logic [sbc_pkg::CNT_W-1:0] elem_cnt_m = 7'd64;
  logic [sbc_pkg::SEQ_W-1:0] base_seq_m = 32'd1;
  logic [sbc_pkg::SEQ_W-1:0] step_limit_m = 32'd0;
  logic                      req_all_m = 1'b1;
  logic                      strict_m = 1'b0;
  logic [63:0]               ready_bits_m = '0;
  logic [63:0]               done_bits_m = '0;
  logic                      running_m = 1'b0;
  logic [sbc_pkg::SEQ_W-1:0] step_seq_m = '0;
  logic [sbc_pkg::SEQ_W-1:0] step_total_m = '0;
  logic [sbc_pkg::SEQ_W-1:0] warn_total_m = '0;
  logic                      halted_m = 1'b0;

  // stimulus-side tracking of the step sequence
  int                        gen_cnt;
  logic [63:0]               gen_mask;
  logic [63:0]               gen_done;
  logic [sbc_pkg::SEQ_W-1:0] gen_seq;
  logic [sbc_pkg::SEQ_W-1:0] gen_total;
  logic [sbc_pkg::SEQ_W-1:0] gen_max;

  pe_report_t      pending_reports[$];
  barrier_result_t pending_results[$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit item_taken = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int eff_count(logic [sbc_pkg::CNT_W-1:0] pc);
    if (pc < 1) return 1;
    if (pc > sbc_pkg::NUM_PE) return sbc_pkg::NUM_PE;
    return int'(pc);
  endfunction

  function automatic logic [63:0] mask_of(int n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic sbc_pkg::status_t violation(sbc_pkg::status_t warn_status);
    if (strict_m) begin
      halted_m = 1'b1;
      return sbc_pkg::ST_FATAL;
    end
    if (warn_total_m != 32'hFFFF_FFFF) warn_total_m++;
    return warn_status;
  endfunction

  task automatic barrier_predict(sbc_pkg::cmd_t cmd, logic [sbc_pkg::CNT_W-1:0] idx,
                                 logic [sbc_pkg::SEQ_W-1:0] seq);
    barrier_result_t r;
    logic [63:0] mask;
    int cnt;
    cnt = eff_count(elem_cnt_m);
    mask = mask_of(cnt);
    if (halted_m) begin
      r.status = sbc_pkg::ST_HALTED;
    end else if (idx >= cnt || cmd == sbc_pkg::CMD_UNKNOWN) begin
      r.status = sbc_pkg::ST_IGNORED;
    end else if (cmd == sbc_pkg::CMD_READY) begin
      ready_bits_m[idx] = 1'b1;
      r.status = sbc_pkg::ST_READY;
      if (!running_m && (!req_all_m || (ready_bits_m & mask) == mask)) begin
        running_m = 1'b1;
        step_seq_m = (base_seq_m == 0) ? 32'd1 : base_seq_m;
        done_bits_m = '0;
        r.status = sbc_pkg::ST_STARTED;
      end
    end else if (cmd == sbc_pkg::CMD_DONE) begin
      if (!running_m) begin
        r.status = violation(sbc_pkg::ST_EARLY_DONE);
      end else if (seq != step_seq_m) begin
        r.status = violation(sbc_pkg::ST_SEQ_MISMATCH);
      end else begin
        done_bits_m[idx] = 1'b1;
        r.status = sbc_pkg::ST_DONE;
        if ((done_bits_m & mask) == mask) begin
          step_total_m++;
          if (step_limit_m != 0 && step_total_m >= step_limit_m) begin
            r.status = sbc_pkg::ST_MAX;
          end else begin
            step_seq_m++;
            done_bits_m = '0;
            r.status = sbc_pkg::ST_STARTED;
          end
        end
      end
    end else begin
      r.status = violation(sbc_pkg::ST_STRAY_START);
    end
    r.step = step_seq_m;
    r.total = step_total_m;
    r.warns = warn_total_m;
    pending_results = {pending_results, r};
  endtask

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    pe_report_t it;
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n && (!in_valid || item_taken)) begin
      item_taken = 1'b0;
      if (pending_reports.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_reports.pop_front();
        in_valid <= 1'b1;
        in_cmd <= it.cmd;
        in_elem_id <= it.pe;
        in_step_number <= it.seq;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    barrier_result_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result status %0d", out_status));
        end else begin
          e = pending_results.pop_front();
          if (out_status !== e.status)
            flag_mismatch($sformatf("status %0d, want %0d", out_status, e.status));
          if (out_current_step !== e.step)
            flag_mismatch($sformatf("current_step %0h, want %0h", out_current_step, e.step));
          if (out_completed_steps !== e.total)
            flag_mismatch($sformatf("completed_steps %0h, want %0h",
                                    out_completed_steps, e.total));
          if (out_warnings !== e.warns)
            flag_mismatch($sformatf("warnings %0h, want %0h", out_warnings, e.warns));
        end
      end
      if (in_valid && !in_stall) begin
        barrier_predict(sbc_pkg::cmd_t'(in_cmd), in_elem_id, in_step_number);
        item_taken = 1'b1;
      end
    end
  end

  task automatic queue_item(sbc_pkg::cmd_t c, int pe, logic [sbc_pkg::SEQ_W-1:0] s);
    pe_report_t it;
    it.cmd = c;
    it.pe = pe[sbc_pkg::CNT_W-1:0];
    it.seq = s;
    pending_reports = {pending_reports, it};
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reports.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(sbc_pkg::reg_idx_t idx, logic [sbc_pkg::SEQ_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      sbc_pkg::REG_PE_COUNT:  elem_cnt_m = val[sbc_pkg::CNT_W-1:0];
      sbc_pkg::REG_START_SEQ: base_seq_m = val;
      sbc_pkg::REG_MAX_STEPS: step_limit_m = val;
      sbc_pkg::REG_REQ_ALL:   req_all_m = val[0];
      sbc_pkg::REG_STRICT:    strict_m = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic sync_gen();
    gen_cnt = eff_count(elem_cnt_m);
    gen_mask = mask_of(gen_cnt);
    gen_seq = step_seq_m;
    gen_total = step_total_m;
    gen_done = done_bits_m;
    gen_max = step_limit_m;
  endtask

  task automatic emit_done(int pe);
    queue_item(sbc_pkg::CMD_DONE, pe, gen_seq);
    gen_done[pe] = 1'b1;
    if ((gen_done & gen_mask) == gen_mask) begin
      gen_total++;
      if (!(gen_max != 0 && gen_total >= gen_max)) begin
        gen_seq++;
        gen_done = '0;
      end
    end
  endtask

  // clean noise never breaks the protocol; the rest may
  task automatic queue_noise(bit clean);
    case ($urandom_range(clean ? 2 : 5))
      0: queue_item(sbc_pkg::CMD_UNKNOWN, $urandom_range(127), $urandom);
      1: queue_item(sbc_pkg::cmd_t'($urandom_range(3)), $urandom_range(127, gen_cnt),
                    $urandom);
      2: queue_item(sbc_pkg::CMD_READY, $urandom_range(gen_cnt - 1), $urandom);
      3: queue_item(sbc_pkg::CMD_DONE, $urandom_range(gen_cnt - 1),
                    gen_seq ^ ($urandom | 32'd1));
      4: queue_item(sbc_pkg::CMD_START, $urandom_range(gen_cnt - 1), $urandom);
      default: queue_item(sbc_pkg::CMD_DONE, $urandom_range(gen_cnt - 1),
                          $urandom_range(1) ? gen_seq + 32'd1 : gen_seq - 32'd1);
    endcase
  endtask

  task automatic random_phase(int budget, bit clean);
    int order[$];
    int k;
    int j;
    int tmp;
    sync_gen();
    while (budget > 0) begin
      order = {};
      for (k = 0; k < gen_cnt; k++)
        if (!gen_done[k]) order = {order, k};
      if (order.size() == 0) order = {order, 0};
      for (k = order.size() - 1; k > 0; k--) begin
        j = $urandom_range(k);
        tmp = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      for (k = 0; k < order.size(); k++) begin
        if ($urandom_range(99) < 8) begin
          queue_noise(clean);
          budget--;
        end
        if (!clean && $urandom_range(99) < 3) continue;
        emit_done(order[k]);
        budget--;
      end
      if ($urandom_range(99) < 10) begin
        queue_item(sbc_pkg::CMD_READY, $urandom_range(gen_cnt - 1), $urandom);
        budget--;
      end
    end
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  initial begin
    logic [sbc_pkg::SEQ_W-1:0] first_seq;
    logic [sbc_pkg::SEQ_W-1:0] s;
    logic [sbc_pkg::SEQ_W-1:0] maxv;
    logic [sbc_pkg::CNT_W-1:0] pc;
    int ph;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // before the first step, default configuration
    queue_item(sbc_pkg::CMD_DONE, 0, 32'd0);
    queue_item(sbc_pkg::CMD_START, 63, 32'hFFFF_FFFF);
    queue_item(sbc_pkg::CMD_UNKNOWN, 0, 32'd0);
    queue_item(sbc_pkg::CMD_READY, 127, 32'd0);
    queue_item(sbc_pkg::CMD_READY, 64, 32'd0);
    queue_item(sbc_pkg::CMD_READY, 63, 32'd0);
    queue_item(sbc_pkg::CMD_READY, 0, 32'd0);
    wait_idle();

    case ($urandom_range(2))
      0: first_seq = 32'd0;
      1: first_seq = 32'hFFFF_FFFE;
      default: first_seq = $urandom;
    endcase
    write_reg(sbc_pkg::REG_START_SEQ, 32'hFFFF_FFFF);
    write_reg(sbc_pkg::REG_PE_COUNT, 32'd3);
    write_reg(sbc_pkg::REG_START_SEQ, first_seq);
    write_reg(sbc_pkg::REG_REQ_ALL, $urandom_range(1));
    queue_item(sbc_pkg::CMD_READY, 1, 32'd0);
    queue_item(sbc_pkg::CMD_READY, 2, 32'd0);
    wait_idle();

    s = step_seq_m;
    queue_item(sbc_pkg::CMD_DONE, 0, s);
    queue_item(sbc_pkg::CMD_DONE, 1, s + 32'd1);
    queue_item(sbc_pkg::CMD_DONE, 1, s);
    queue_item(sbc_pkg::CMD_DONE, 3, s);
    queue_item(sbc_pkg::CMD_DONE, 2, s);
    queue_item(sbc_pkg::CMD_READY, 0, 32'd0);
    queue_item(sbc_pkg::CMD_START, 1, s);
    wait_idle();

    // max reached, then counted again, then released
    write_reg(sbc_pkg::REG_MAX_STEPS, step_total_m + 32'd1);
    s = step_seq_m;
    queue_item(sbc_pkg::CMD_DONE, 0, s);
    queue_item(sbc_pkg::CMD_DONE, 1, s);
    queue_item(sbc_pkg::CMD_DONE, 2, s);
    queue_item(sbc_pkg::CMD_DONE, 0, s);
    wait_idle();
    write_reg(sbc_pkg::REG_MAX_STEPS, 32'd0);
    queue_item(sbc_pkg::CMD_DONE, 1, step_seq_m);
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_idling(0, 0);
        1: set_idling(65, 0);
        2: set_idling(0, 65);
        default: set_idling(19, 19);
      endcase
      case (ph)
        0: pc = 7'd1;
        1: pc = 7'd64;
        2: pc = 7'd0;
        3: pc = 7'd127;
        default: pc = $urandom_range(9, 2);
      endcase
      case (ph % 3)
        0: maxv = 32'd0;
        1: maxv = step_total_m + $urandom_range(6, 2);
        default: maxv = step_total_m + 32'd1;
      endcase
      if (ph == 7) maxv = 32'hFFFF_FFFF;
      write_reg(sbc_pkg::REG_PE_COUNT, {25'd0, pc});
      write_reg(sbc_pkg::REG_MAX_STEPS, maxv);
      write_reg(sbc_pkg::REG_START_SEQ, (ph == 0) ? 32'd0 : $urandom);
      write_reg(sbc_pkg::REG_REQ_ALL, $urandom_range(1));
      write_reg(sbc_pkg::REG_STRICT, (ph == 5) ? 32'd1 : 32'd0);
      random_phase(85, ph == 5);
      wait_idle();
      random_phase(85, ph == 5);
      wait_idle();
    end

    // strict violations halt the barrier for the rest of the run
    set_idling(19, 19);
    write_reg(sbc_pkg::REG_PE_COUNT, $urandom_range(6, 2));
    write_reg(sbc_pkg::REG_MAX_STEPS, 32'd0);
    write_reg(sbc_pkg::REG_STRICT, 32'd1);
    random_phase(10, 1'b1);
    wait_idle();
    random_phase(30, 1'b0);
    queue_item(sbc_pkg::CMD_START, 0, $urandom);
    queue_item(sbc_pkg::CMD_DONE, 1, $urandom);
    wait_idle();
    write_reg(sbc_pkg::REG_PE_COUNT, 32'd64);
    write_reg(sbc_pkg::REG_REQ_ALL, 32'd0);
    queue_item(sbc_pkg::CMD_READY, 0, 32'd0);
    queue_item(sbc_pkg::CMD_DONE, 0, step_seq_m);
    queue_item(sbc_pkg::CMD_UNKNOWN, 127, 32'hFFFF_FFFF);
    wait_idle();

    repeat (8) @(negedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
